FILE: rtl/core/mqlb_pkg.sv
// Package for the multi-queue linked buffer: shared constants, codes and the
// controller/datapath command and status structs. No dependencies.
package mqlb_pkg;

	localparam int NUM_QUEUES_DEF  = 10;
	localparam int POOL_DEPTH_DEF  = 256;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int QUEUE_ID_W = 4;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 2;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // request taken, latch it and issue pointer reads
		logic lookup;  // dequeue: read node value and link at head
		logic commit;  // apply updates and load the result register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_lookup;
	} dp_stat_t;

endpackage

FILE: rtl/core/mqlb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mqlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/mqlb_ctrl.sv
// Sequencer for the multi-queue linked buffer: request handshake, phase state
// machine and result-register valid. Depends on mqlb_pkg.
module mqlb_ctrl
	import mqlb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOKUP = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free  = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign ctl.accept = in_valid && (state_q == S_IDLE);
	assign ctl.lookup = (state_q == S_LOOKUP);
	assign ctl.commit = (state_q == S_COMMIT) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = stat.needs_lookup ? S_LOOKUP : S_COMMIT;
				end
			end
			S_LOOKUP: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_rose_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_COMMIT)
		else $error("result valid rose without a commit");

	a_lookup_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOKUP |=> state_q == S_COMMIT)
		else $error("lookup phase not followed by commit");

	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> state_q == S_IDLE && out_valid_q)
		else $error("commit did not return to idle with a result");

endmodule

FILE: rtl/core/mqlb_dp.sv
// Datapath for the multi-queue linked buffer: request registers, queue flags,
// free-list state, pointer/link/value RAMs and result register.
// Depends on mqlb_pkg and mqlb_ram.
module mqlb_dp
	import mqlb_pkg::*;
#(
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
	parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd,
	input  logic [QUEUE_ID_W-1:0]      queue_id,
	input  logic signed [DATA_W-1:0]   in_value,
	input  ctl_cmd_t                   ctl,
	output dp_stat_t                   stat,
	output logic signed [DATA_W-1:0]   out_value,
	output logic [STATUS_W-1:0]        status
);

	localparam int QID_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W = $clog2(POOL_DEPTH);
	localparam int CNT_W = $clog2(POOL_DEPTH + 1);
	localparam int QX_W  = ((QID_W > QUEUE_ID_W) ? QID_W : QUEUE_ID_W) + 1;
	localparam int VX_W  = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

	// request registers
	logic                   cmd_q;
	logic [QID_W-1:0]       q_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   err_q;

	logic [NUM_QUEUES-1:0]  nonempty_q;
	logic [PTR_W-1:0]       free_head_q;
	logic [CNT_W-1:0]       free_count_q;
	logic [CNT_W-1:0]       fresh_used_q;

	logic [DATA_W-1:0]      out_value_q;
	logic [STATUS_W-1:0]    status_q;

	logic [QX_W-1:0]        queue_id_x;
	logic [QID_W-1:0]       q_addr;
	logic                   q_in_range;
	logic                   pool_empty;
	logic                   acc_err;
	logic [VX_W-1:0]        in_x;
	logic [VX_W-1:0]        val_x;

	logic [PTR_W-1:0]       head_rd, tail_rd, link_rd;
	logic [VALUE_WIDTH-1:0] value_rd;

	logic                   enq_ok, deq_ok;
	logic                   use_free, tail_match, q_busy;
	logic [PTR_W-1:0]       new_node;

	logic                   head_we, link_we;
	logic [PTR_W-1:0]       head_wdata, link_waddr, link_wdata, link_raddr;

	assign queue_id_x = QX_W'(queue_id);
	assign q_addr     = queue_id_x[QID_W-1:0];
	assign q_in_range = queue_id_x < QX_W'(NUM_QUEUES);
	assign pool_empty = (free_count_q == '0) && (fresh_used_q == CNT_W'(POOL_DEPTH));
	assign acc_err    = (cmd == CMD_ENQ) ? (!q_in_range || pool_empty)
	                                     : (!q_in_range || !nonempty_q[q_addr]);
	assign stat.needs_lookup = (cmd == CMD_DEQ) && !acc_err;

	assign in_x  = VX_W'($unsigned(in_value));
	assign val_x = VX_W'(value_rd);

	assign enq_ok     = ctl.commit && (cmd_q == CMD_ENQ) && !err_q;
	assign deq_ok     = ctl.commit && (cmd_q == CMD_DEQ) && !err_q;
	assign use_free   = (free_count_q != '0);
	assign new_node   = use_free ? free_head_q : fresh_used_q[PTR_W-1:0];
	assign tail_match = (head_rd == tail_rd);
	assign q_busy     = nonempty_q[q_q];

	// an enqueue to an empty queue sets head; a dequeue that leaves nodes advances it
	assign head_we    = (enq_ok && !q_busy) || (deq_ok && !tail_match);
	assign head_wdata = enq_ok ? new_node : link_rd;

	// dequeue pushes the head node on the free list; enqueue links after tail
	assign link_we    = (enq_ok && q_busy) || deq_ok;
	assign link_waddr = deq_ok ? head_rd : tail_rd;
	assign link_wdata = deq_ok ? free_head_q : new_node;
	assign link_raddr = ctl.lookup ? head_rd : free_head_q;

	mqlb_ram #(.WIDTH(PTR_W), .DEPTH(NUM_QUEUES)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (q_q),
		.wdata (head_wdata),
		.re    (ctl.accept),
		.raddr (q_addr),
		.rdata (head_rd)
	);

	mqlb_ram #(.WIDTH(PTR_W), .DEPTH(NUM_QUEUES)) u_tail_ram (
		.clk   (clk),
		.we    (enq_ok),
		.waddr (q_q),
		.wdata (new_node),
		.re    (ctl.accept),
		.raddr (q_addr),
		.rdata (tail_rd)
	);

	mqlb_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (ctl.accept || ctl.lookup),
		.raddr (link_raddr),
		.rdata (link_rd)
	);

	mqlb_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (enq_ok),
		.waddr (new_node),
		.wdata (value_q),
		.re    (ctl.lookup),
		.raddr (head_rd),
		.rdata (value_rd)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= cmd;
			q_q     <= q_addr;
			value_q <= in_x[VALUE_WIDTH-1:0];
			err_q   <= acc_err;
		end
		if (ctl.commit) begin
			out_value_q <= deq_ok ? val_x[DATA_W-1:0] : '0;
			if (!err_q) begin
				status_q <= ST_OK;
			end else begin
				status_q <= (cmd_q == CMD_ENQ) ? ST_FULL : ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q   <= '0;
			free_head_q  <= '0;
			free_count_q <= '0;
			fresh_used_q <= '0;
		end else begin
			if (enq_ok) begin
				nonempty_q[q_q] <= 1'b1;
				if (use_free) begin
					free_head_q  <= link_rd;
					free_count_q <= free_count_q - 1'b1;
				end else begin
					fresh_used_q <= fresh_used_q + 1'b1;
				end
			end else if (deq_ok) begin
				if (tail_match) begin
					nonempty_q[q_q] <= 1'b0;
				end
				free_head_q  <= head_rd;
				free_count_q <= free_count_q + 1'b1;
			end
		end
	end

	assign out_value = out_value_q;
	assign status    = status_q;

	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= fresh_used_q)
		else $error("free list longer than nodes ever handed out");

	a_last_deq_clears: assert property (@(posedge clk) disable iff (!arst_n)
		deq_ok && tail_match |=> !nonempty_q[$past(q_q)])
		else $error("queue still flagged after its last node left");

	a_enq_sets: assert property (@(posedge clk) disable iff (!arst_n)
		enq_ok |=> nonempty_q[$past(q_q)])
		else $error("queue not flagged after enqueue");

endmodule

FILE: rtl/core/multi_queue_linked_buffer_unit.sv
// Top level of the multi-queue linked buffer: several FIFO queues over one
// shared pool of linked nodes. Depends on mqlb_pkg, mqlb_ctrl, mqlb_dp.
//
//   channel   signals                          direction
//   request   in_valid in_stall cmd queue_id in_value   in
//   result    out_valid out_stall out_value status       out
//
// An enqueue or a failed request runs accept then commit, a good dequeue runs
// accept, lookup, commit: pointer RAMs are read first, the dequeue then reads
// value and link at the head, and commit writes pointers, links, free-list state.
// Reset clears the queue flags and free-list counters at once; no clearing pass.
// A finished result waits in the output register; a stalled result holds the
// commit phase until the register frees up.
module multi_queue_linked_buffer_unit
	import mqlb_pkg::*;
#(
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
	parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     cmd,
	input  logic [QUEUE_ID_W-1:0]    queue_id,
	input  logic signed [DATA_W-1:0] in_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_value,
	output logic [STATUS_W-1:0]      status
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	mqlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	mqlb_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.POOL_DEPTH  (POOL_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.queue_id  (queue_id),
		.in_value  (in_value),
		.ctl       (ctl),
		.stat      (stat),
		.out_value (out_value),
		.status    (status)
	);

endmodule
